/* design/reliable_datagram_arq_engine_assert.svh */
// ----------------------------------------------------------------------------
// ARQ engine assertion macros
// Shared property wrappers for the ARQ engine, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_DATAGRAM_ARQ_ENGINE_ASSERT_SVH
`define RELIABLE_DATAGRAM_ARQ_ENGINE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RDARQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define RDARQ_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* design/rdarq_pkg.sv */
// ----------------------------------------------------------------------------
// ARQ engine package
// Constants, codes and controller/datapath interface types of the ARQ engine.
// ----------------------------------------------------------------------------
package rdarq_pkg;

   // The slot table size must be a power of two; slots are sequence low bits.
   localparam int ENTRIES  = 64;
   localparam int SLOT_W   = $clog2(ENTRIES);
   localparam int SEQ_W    = 32;
   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 10;
   localparam int ENTRY_W  = SEQ_W + TIME_W + HANDLE_W;
   localparam int CFG_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] OP_SEND  = 2'd0;
   localparam logic [1:0] OP_FRAME = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [7:0] FT_DATA = 8'd0;
   localparam logic [7:0] FT_ACK  = 8'd1;

   localparam logic [10:0] MIN_FRAME = 11'd5;

   localparam logic [2:0] KIND_TX      = 3'd0;
   localparam logic [2:0] KIND_RETX    = 3'd1;
   localparam logic [2:0] KIND_ACK     = 3'd2;
   localparam logic [2:0] KIND_DELIVER = 3'd3;
   localparam logic [2:0] KIND_REFUSED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_PERIOD = 1'd1;

   localparam logic [CFG_W-1:0] TIMEOUT_RESET = 8'd2;
   localparam logic [CFG_W-1:0] PERIOD_RESET  = 8'd1;

   typedef struct packed {
      logic load_req;
      logic do_send;
      logic emit_ack;
      logic emit_dlv;
      logic ack_clear;
      logic tick;
      logic scan_step;
      logic flush;
      logic scan_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_send;
      logic req_data;
      logic req_ack;
      logic req_tick;
      logic out_free;
      logic scan_now;
      logic due;
      logic pend_valid;
      logic idx_last;
   } dp_status_type;

endpackage

/* design/rdarq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rdarq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rdarq_datapath.sv */
// ----------------------------------------------------------------------------
// ARQ engine datapath
// Input capture, sequence and tick counters, entry table with valid bits,
// retransmission scan logic, pending result and output register.
// ----------------------------------------------------------------------------
module rdarq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_op,
   input  logic [rdarq_pkg::HANDLE_W-1:0]    req_handle,
   input  logic [rdarq_pkg::SEQ_W-1:0]       req_frame_seq,
   input  logic [7:0]                        req_frame_type,
   input  logic [10:0]                       req_frame_length,
   input  logic                              csr_write_enable,
   input  logic [rdarq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdarq_pkg::CFG_W-1:0]       csr_write_data,
   input  rdarq_pkg::ctrl_cmd_type           cmd,
   output rdarq_pkg::dp_status_type          status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_kind,
   output logic [rdarq_pkg::SEQ_W-1:0]       rsp_seq_no,
   output logic [rdarq_pkg::HANDLE_W-1:0]    rsp_out_handle,
   output logic                              rsp_last
);

   localparam int SW = rdarq_pkg::SLOT_W;
   localparam int QW = rdarq_pkg::SEQ_W;
   localparam int TW = rdarq_pkg::TIME_W;
   localparam int HW = rdarq_pkg::HANDLE_W;
   localparam int EW = rdarq_pkg::ENTRY_W;
   localparam int CW = rdarq_pkg::CFG_W;

   logic [HW-1:0]                    handle_ff, handle_in;
   logic [QW-1:0]                    frame_seq_ff, frame_seq_in;
   logic [QW-1:0]                    next_seq_ff, next_seq_in;
   logic [TW-1:0]                    now_ff, now_in;
   logic [CW-1:0]                    countdown_ff, countdown_in;
   logic [CW-1:0]                    timeout_ff, timeout_in;
   logic [CW-1:0]                    period_ff, period_in;
   logic [rdarq_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [SW-1:0]                    idx_ff, idx_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [QW-1:0]                    pend_seq_ff, pend_seq_in;
   logic [HW-1:0]                    pend_handle_ff, pend_handle_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [2:0]                       rsp_kind_ff, rsp_kind_in;
   logic [QW-1:0]                    rsp_seq_ff, rsp_seq_in;
   logic [HW-1:0]                    rsp_handle_ff, rsp_handle_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [SW-1:0] send_slot, frame_slot, rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;
   logic          wr_en;
   logic [QW-1:0] ram_seq;
   logic [TW-1:0] ram_time, age;
   logic [HW-1:0] ram_handle;
   logic          slot_busy, due, ack_match, out_free, out_load, push_pend;

   assign send_slot  = next_seq_ff[SW-1:0];
   assign frame_slot = frame_seq_ff[SW-1:0];
   assign rd_addr    = cmd.scan_sel ? idx_ff : frame_slot;

   assign ram_seq    = rd_data[EW-1 -: QW];
   assign ram_time   = rd_data[HW +: TW];
   assign ram_handle = rd_data[HW-1:0];

   assign age       = now_ff - ram_time;
   assign due       = valid_ff[idx_ff] && (age >= {{(TW-CW){1'b0}}, timeout_ff});
   assign slot_busy = valid_ff[send_slot];
   assign ack_match = valid_ff[frame_slot] && (ram_seq == frame_seq_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_pend = cmd.scan_step && due && pend_valid_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = send_slot;
      wr_data = {next_seq_ff, now_ff, handle_ff};
      if (cmd.do_send && !slot_busy) begin
         wr_en = 1'b1;
      end else if (cmd.scan_step && due) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = {ram_seq, now_ff, ram_handle};
      end
   end

   rdarq_ram #(
      .WIDTH (EW),
      .DEPTH (rdarq_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      handle_in    = cmd.load_req ? req_handle : handle_ff;
      frame_seq_in = cmd.load_req ? req_frame_seq : frame_seq_ff;

      timeout_in = timeout_ff;
      period_in  = period_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rdarq_pkg::REG_TIMEOUT:     timeout_in = csr_write_data;
            rdarq_pkg::REG_SCAN_PERIOD: period_in  = csr_write_data;
            default: begin
            end
         endcase
      end

      next_seq_in = next_seq_ff;
      valid_in    = valid_ff;
      if (cmd.do_send && !slot_busy) begin
         next_seq_in         = next_seq_ff + 1'b1;
         valid_in[send_slot] = 1'b1;
      end
      if (cmd.ack_clear && ack_match) begin
         valid_in[frame_slot] = 1'b0;
      end

      now_in       = now_ff;
      countdown_in = countdown_ff;
      if (cmd.tick) begin
         now_in       = now_ff + 1'b1;
         countdown_in = status.scan_now ? period_ff : countdown_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.scan_step) begin
         idx_in = status.idx_last ? '0 : idx_ff + 1'b1;
      end

      pend_valid_in  = pend_valid_ff;
      pend_seq_in    = pend_seq_ff;
      pend_handle_in = pend_handle_ff;
      if (cmd.scan_step && due) begin
         pend_valid_in  = 1'b1;
         pend_seq_in    = ram_seq;
         pend_handle_in = ram_handle;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      out_load      = 1'b1;
      rsp_kind_in   = rdarq_pkg::KIND_RETX;
      rsp_seq_in    = pend_seq_ff;
      rsp_handle_in = pend_handle_ff;
      rsp_last_in   = 1'b1;
      if (cmd.do_send) begin
         rsp_kind_in   = slot_busy ? rdarq_pkg::KIND_REFUSED : rdarq_pkg::KIND_TX;
         rsp_seq_in    = next_seq_ff;
         rsp_handle_in = handle_ff;
      end else if (cmd.emit_ack || cmd.emit_dlv) begin
         rsp_kind_in   = cmd.emit_ack ? rdarq_pkg::KIND_ACK : rdarq_pkg::KIND_DELIVER;
         rsp_seq_in    = frame_seq_ff;
         rsp_handle_in = handle_ff;
         rsp_last_in   = cmd.emit_dlv;
      end else if (push_pend) begin
         rsp_last_in = 1'b0;
      end else if (!cmd.flush) begin
         out_load = 1'b0;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff   <= '0;
         now_ff        <= '0;
         countdown_ff  <= rdarq_pkg::PERIOD_RESET;
         timeout_ff    <= rdarq_pkg::TIMEOUT_RESET;
         period_ff     <= rdarq_pkg::PERIOD_RESET;
         valid_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         next_seq_ff   <= next_seq_in;
         now_ff        <= now_in;
         countdown_ff  <= countdown_in;
         timeout_ff    <= timeout_in;
         period_ff     <= period_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff      <= handle_in;
      frame_seq_ff   <= frame_seq_in;
      pend_seq_ff    <= pend_seq_in;
      pend_handle_ff <= pend_handle_in;
      if (out_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_seq_ff    <= rsp_seq_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_comb begin
      status.req_send   = (req_op == rdarq_pkg::OP_SEND);
      status.req_data   = (req_op == rdarq_pkg::OP_FRAME) &&
                          (req_frame_length >= rdarq_pkg::MIN_FRAME) &&
                          (req_frame_type == rdarq_pkg::FT_DATA);
      status.req_ack    = (req_op == rdarq_pkg::OP_FRAME) &&
                          (req_frame_length >= rdarq_pkg::MIN_FRAME) &&
                          (req_frame_type == rdarq_pkg::FT_ACK);
      status.req_tick   = (req_op == rdarq_pkg::OP_TICK);
      status.out_free   = out_free;
      status.scan_now   = (countdown_ff <= CW'(1));
      status.due        = due;
      status.pend_valid = pend_valid_ff;
      status.idx_last   = (idx_ff == SW'(rdarq_pkg::ENTRIES - 1));
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_seq_no     = rsp_seq_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* design/rdarq_ctrl.sv */
// ----------------------------------------------------------------------------
// ARQ engine controller
// Sequences each accepted item through the datapath: send, data frame,
// ack lookup, tick and the retransmission scan over the entry table.
// ----------------------------------------------------------------------------
module rdarq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rdarq_pkg::dp_status_type   status,
   output rdarq_pkg::ctrl_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SEND     = 4'd1;
   localparam logic [3:0] S_DATA_ACK = 4'd2;
   localparam logic [3:0] S_DATA_DLV = 4'd3;
   localparam logic [3:0] S_ACK_RD   = 4'd4;
   localparam logic [3:0] S_ACK_CHK  = 4'd5;
   localparam logic [3:0] S_TICK     = 4'd6;
   localparam logic [3:0] S_SCAN_RD  = 4'd7;
   localparam logic [3:0] S_SCAN_CHK = 4'd8;
   localparam logic [3:0] S_FLUSH    = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (status.req_send) begin
                  state_in = S_SEND;
               end else if (status.req_data) begin
                  state_in = S_DATA_ACK;
               end else if (status.req_ack) begin
                  state_in = S_ACK_RD;
               end else if (status.req_tick) begin
                  state_in = S_TICK;
               end
            end
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.do_send = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DATA_ACK: begin
            if (status.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_DATA_DLV;
            end
         end
         S_DATA_DLV: begin
            if (status.out_free) begin
               cmd.emit_dlv = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ACK_RD: begin
            state_in = S_ACK_CHK;
         end
         S_ACK_CHK: begin
            cmd.ack_clear = 1'b1;
            state_in      = S_IDLE;
         end
         S_TICK: begin
            cmd.tick = 1'b1;
            state_in = status.scan_now ? S_SCAN_RD : S_IDLE;
         end
         S_SCAN_RD: begin
            cmd.scan_sel = 1'b1;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.scan_sel = 1'b1;
            if (!(status.due && status.pend_valid && !status.out_free)) begin
               cmd.scan_step = 1'b1;
               state_in      = status.idx_last ? S_FLUSH : S_SCAN_RD;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/reliable_datagram_arq_engine.sv */
// ----------------------------------------------------------------------------
// Reliable datagram ARQ engine
// Sequence numbering, unacknowledged entry table and timed retransmission.
// ----------------------------------------------------------------------------
// The engine takes one item at a time. A send request and a data frame wait
// for the result register to drain when it is held; an ack frame reads its
// slot in S_ACK_RD and checks it in S_ACK_CHK. A scanning tick walks the entry
// table one slot at a time, reading in S_SCAN_RD and checking in S_SCAN_CHK,
// since the entry table is one RAM with a single registered read port. Ack
// frames and ticks still occupy the engine when they cause no result.
module reliable_datagram_arq_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic [rdarq_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [rdarq_pkg::SEQ_W-1:0]      req_frame_seq,
   input  logic [7:0]                       req_frame_type,
   input  logic [10:0]                      req_frame_length,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_kind,
   output logic [rdarq_pkg::SEQ_W-1:0]      rsp_seq_no,
   output logic [rdarq_pkg::HANDLE_W-1:0]   rsp_out_handle,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [rdarq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rdarq_pkg::CFG_W-1:0]      csr_write_data
);

   rdarq_pkg::ctrl_cmd_type  cmd;
   rdarq_pkg::dp_status_type status;

   rdarq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdarq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_handle       (req_handle),
      .req_frame_seq    (req_frame_seq),
      .req_frame_type   (req_frame_type),
      .req_frame_length (req_frame_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_seq_no       (rsp_seq_no),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_last         (rsp_last)
   );

`include "reliable_datagram_arq_engine_assert.svh"

   `RDARQ_NEVER(a_pend_outlives_scan, req_ready && status.pend_valid, "retransmit pending while idle")
   `RDARQ_NEVER(a_open_item_ready, rsp_valid && !rsp_last && req_ready, "ready before final result")
   `RDARQ_ASSERT(a_quiet_tick, req_valid && req_ready && status.req_tick && !status.scan_now |=> ##1 req_ready, "tick without scan did not finish")

endmodule

/* tb/sv/arq_engine_checker.sv */
// ----------------------------------------------------------------------------
// ARQ engine checker
// Watches the request, result and register ports of the ARQ engine. It keeps
// its own copy of the sequence counter, tick clock and entry table, works out
// the results of every accepted request and compares each result transfer
// with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module arq_engine_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic [rdarq_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [rdarq_pkg::SEQ_W-1:0]      req_frame_seq,
   input  logic [7:0]                       req_frame_type,
   input  logic [10:0]                      req_frame_length,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_kind,
   input  logic [rdarq_pkg::SEQ_W-1:0]      rsp_seq_no,
   input  logic [rdarq_pkg::HANDLE_W-1:0]   rsp_out_handle,
   input  logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [rdarq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rdarq_pkg::CFG_W-1:0]      csr_write_data,
   output int                               fail_count,
   output int                               pending_count,
   output logic [rdarq_pkg::SEQ_W-1:0]      issued_seq
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [10:0] MAX_FRAME_LEN = 11'd1600;

   typedef struct packed {
      logic [2:0]                     kind;
      logic [rdarq_pkg::SEQ_W-1:0]    seq_no;
      logic [rdarq_pkg::HANDLE_W-1:0] handle;
      logic                           is_last;
   } engine_output_type;

   engine_output_type              pending_outputs[$];
   int                             mismatches = 0;

   logic [rdarq_pkg::CFG_W-1:0]    cfg_timeout;
   logic [rdarq_pkg::CFG_W-1:0]    cfg_period;
   logic [rdarq_pkg::SEQ_W-1:0]    next_seq;
   logic [rdarq_pkg::TIME_W-1:0]   now_ticks;
   logic [rdarq_pkg::CFG_W-1:0]    scan_countdown;
   logic                           slot_busy   [rdarq_pkg::ENTRIES];
   logic [rdarq_pkg::SEQ_W-1:0]    slot_seq    [rdarq_pkg::ENTRIES];
   logic [rdarq_pkg::TIME_W-1:0]   slot_stamp  [rdarq_pkg::ENTRIES];
   logic [rdarq_pkg::HANDLE_W-1:0] slot_handle [rdarq_pkg::ENTRIES];

   task automatic push_output(input logic [2:0] kind,
                              input logic [rdarq_pkg::SEQ_W-1:0] seq_no,
                              input logic [rdarq_pkg::HANDLE_W-1:0] handle);
      engine_output_type o;
      o.kind    = kind;
      o.seq_no  = seq_no;
      o.handle  = handle;
      o.is_last = 1'b0;
      pending_outputs.push_back(o);
   endtask

   task automatic advance_engine(input logic [1:0] op,
                                 input logic [rdarq_pkg::HANDLE_W-1:0] handle,
                                 input logic [rdarq_pkg::SEQ_W-1:0] fseq,
                                 input logic [7:0] ftype,
                                 input logic [10:0] flen);
      int                           first;
      int                           i;
      logic [rdarq_pkg::SLOT_W-1:0] slot;
      logic [10:0]                  eff_len;
      logic [rdarq_pkg::TIME_W-1:0] age;
      first = pending_outputs.size();
      case (op)
         rdarq_pkg::OP_SEND: begin
            slot = next_seq[rdarq_pkg::SLOT_W-1:0];
            if (slot_busy[slot]) begin
               push_output(rdarq_pkg::KIND_REFUSED, next_seq, handle);
            end else begin
               slot_busy[slot]   = 1'b1;
               slot_seq[slot]    = next_seq;
               slot_stamp[slot]  = now_ticks;
               slot_handle[slot] = handle;
               push_output(rdarq_pkg::KIND_TX, next_seq, handle);
               next_seq = next_seq + 1'b1;
            end
         end
         rdarq_pkg::OP_FRAME: begin
            eff_len = (flen > MAX_FRAME_LEN) ? MAX_FRAME_LEN : flen;
            if (eff_len >= rdarq_pkg::MIN_FRAME) begin
               if (ftype == rdarq_pkg::FT_DATA) begin
                  push_output(rdarq_pkg::KIND_ACK, fseq, handle);
                  push_output(rdarq_pkg::KIND_DELIVER, fseq, handle);
               end else if (ftype == rdarq_pkg::FT_ACK) begin
                  slot = fseq[rdarq_pkg::SLOT_W-1:0];
                  if (slot_busy[slot] && slot_seq[slot] == fseq) begin
                     slot_busy[slot] = 1'b0;
                  end
               end
            end
         end
         rdarq_pkg::OP_TICK: begin
            now_ticks = now_ticks + 1'b1;
            if (scan_countdown <= 1) begin
               scan_countdown = cfg_period;
               for (i = 0; i < rdarq_pkg::ENTRIES; i++) begin
                  age = now_ticks - slot_stamp[i];
                  if (slot_busy[i] &&
                      age >= {{(rdarq_pkg::TIME_W - rdarq_pkg::CFG_W){1'b0}}, cfg_timeout})
                  begin
                     push_output(rdarq_pkg::KIND_RETX, slot_seq[i], slot_handle[i]);
                     slot_stamp[i] = now_ticks;
                  end
               end
            end else begin
               scan_countdown = scan_countdown - 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (pending_outputs.size() > first) begin
         pending_outputs[pending_outputs.size()-1].is_last = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch_ports
      engine_output_type want;
      int                i;
      if (reset) begin
         cfg_timeout    = rdarq_pkg::TIMEOUT_RESET;
         cfg_period     = rdarq_pkg::PERIOD_RESET;
         next_seq       = '0;
         now_ticks      = '0;
         scan_countdown = rdarq_pkg::PERIOD_RESET;
         for (i = 0; i < rdarq_pkg::ENTRIES; i++) begin
            slot_busy[i]   = 1'b0;
            slot_seq[i]    = '0;
            slot_stamp[i]  = '0;
            slot_handle[i] = '0;
         end
         pending_outputs.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rdarq_pkg::REG_TIMEOUT:     cfg_timeout = csr_write_data;
               rdarq_pkg::REG_SCAN_PERIOD: cfg_period  = csr_write_data;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            advance_engine(req_op, req_handle, req_frame_seq, req_frame_type,
                           req_frame_length);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $error("unexpected result transfer: kind %0d seq_no %0h out_handle %0h",
                      rsp_kind, rsp_seq_no, rsp_out_handle);
               mismatches++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_seq_no !== want.seq_no) begin
                  $error("seq_no: expected %0h, actual %0h", want.seq_no, rsp_seq_no);
                  mismatches++;
               end
               if (rsp_out_handle !== want.handle) begin
                  $error("out_handle: expected %0h, actual %0h", want.handle,
                         rsp_out_handle);
                  mismatches++;
               end
               if (rsp_last !== want.is_last) begin
                  $error("last: expected %0d, actual %0d", want.is_last, rsp_last);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= pending_outputs.size();
      issued_seq    <= next_seq;
   end

endmodule

/* tb/sv/tb_reliable_datagram_arq_engine.sv */
// ----------------------------------------------------------------------------
// ARQ engine testbench
// Drives send requests, received frames and ticks into the ARQ engine under
// several register settings and idling patterns, including a long receiver
// stall, and reports the verdict of the checker that runs beside the engine.
// ----------------------------------------------------------------------------
module tb_reliable_datagram_arq_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SETTLE_CYCLES = 2 * rdarq_pkg::ENTRIES + 20;
   localparam int          STALL_CYCLES  = 400;
   localparam int          BURST_ITEMS   = 30;
   localparam int          PHASE_ITEMS   = 62;
   localparam int          PHASES        = 6;
   localparam logic [10:0] MAX_FRAME_LEN = 11'd1600;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   typedef struct packed {
      logic [1:0]                     op;
      logic [rdarq_pkg::HANDLE_W-1:0] handle;
      logic [rdarq_pkg::SEQ_W-1:0]    fseq;
      logic [7:0]                     ftype;
      logic [10:0]                    flen;
   } engine_item_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [1:0]                        req_op;
   logic [rdarq_pkg::HANDLE_W-1:0]    req_handle;
   logic [rdarq_pkg::SEQ_W-1:0]       req_frame_seq;
   logic [7:0]                        req_frame_type;
   logic [10:0]                       req_frame_length;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [2:0]                        rsp_kind;
   logic [rdarq_pkg::SEQ_W-1:0]       rsp_seq_no;
   logic [rdarq_pkg::HANDLE_W-1:0]    rsp_out_handle;
   logic                              rsp_last;
   logic                              csr_write_enable;
   logic [rdarq_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [rdarq_pkg::CFG_W-1:0]       csr_write_data;

   int                                fail_count;
   int                                pending_count;
   logic [rdarq_pkg::SEQ_W-1:0]       issued_seq;

   int                                src_idle_pct  = 15;
   int                                sink_idle_pct = 79;
   int                                stall_reqs    = 0;
   int                                stall_seen    = 0;
   int                                stall_left    = 0;

   logic [rdarq_pkg::CFG_W-1:0] phase_timeout [PHASES] =
      '{8'd1, 8'd255, 8'd0, 8'd3, 8'd255, 8'd1};
   logic [rdarq_pkg::CFG_W-1:0] phase_period  [PHASES] =
      '{8'd1, 8'd255, 8'd0, 8'd2, 8'd1, 8'd255};

   reliable_datagram_arq_engine i_dut (.*);

   arq_engine_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // The receiver stall is counted here so that the sender keeps offering
   // items while no result transfer can happen.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_seen != stall_reqs) begin
            stall_seen = stall_reqs;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   function automatic engine_item_type make_item(input logic [1:0] op,
                                                 input logic [rdarq_pkg::HANDLE_W-1:0] handle,
                                                 input logic [rdarq_pkg::SEQ_W-1:0] fseq,
                                                 input logic [7:0] ftype,
                                                 input logic [10:0] flen);
      engine_item_type it;
      it.op     = op;
      it.handle = handle;
      it.fseq   = fseq;
      it.ftype  = ftype;
      it.flen   = flen;
      return it;
   endfunction

   function automatic engine_item_type random_item(input bit results_only);
      engine_item_type it;
      int              r;
      int unsigned     u;
      u         = $urandom_range(0, 1023);
      it.op     = rdarq_pkg::OP_FRAME;
      it.handle = u[rdarq_pkg::HANDLE_W-1:0];
      it.fseq   = $urandom;
      it.ftype  = rdarq_pkg::FT_DATA;
      it.flen   = 11'($urandom_range(rdarq_pkg::MIN_FRAME, MAX_FRAME_LEN));
      r = results_only ? $urandom_range(0, 69) : $urandom_range(0, 99);
      if (r < 34) begin
         it.op = rdarq_pkg::OP_SEND;
      end else if (r < 52) begin
         u        = $urandom_range(0, rdarq_pkg::ENTRIES - 1);
         it.ftype = rdarq_pkg::FT_ACK;
         it.fseq  = issued_seq - 1'b1 - u;
      end else if (r < 56) begin
         it.ftype = rdarq_pkg::FT_ACK;
      end else if (r < 70) begin
         if ($urandom_range(0, 7) == 0) begin
            it.flen = 11'($urandom_range(MAX_FRAME_LEN + 1, 2047));
         end
      end else if (r < 76) begin
         it.ftype = 8'($urandom_range(0, 255));
         it.flen  = 11'($urandom_range(0, 2047));
      end else if (r < 95) begin
         it.op = rdarq_pkg::OP_TICK;
      end else begin
         it.op    = OP_UNUSED;
         it.ftype = 8'($urandom_range(0, 255));
         it.flen  = 11'($urandom_range(0, 2047));
      end
      return it;
   endfunction

   task automatic put_item(input engine_item_type it);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= it.op;
      req_handle       <= it.handle;
      req_frame_seq    <= it.fseq;
      req_frame_type   <= it.ftype;
      req_frame_length <= it.flen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [rdarq_pkg::CFG_W-1:0] timeout_val,
                              input logic [rdarq_pkg::CFG_W-1:0] period_val);
      csr_write_enable <= 1'b1;
      csr_index        <= rdarq_pkg::REG_TIMEOUT;
      csr_write_data   <= timeout_val;
      @(posedge clock);
      csr_index        <= rdarq_pkg::REG_SCAN_PERIOD;
      csr_write_data   <= period_val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int ph;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= rdarq_pkg::OP_SEND;
      req_handle       <= '0;
      req_frame_seq    <= '0;
      req_frame_type   <= '0;
      req_frame_length <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= rdarq_pkg::REG_TIMEOUT;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      put_item(make_item(rdarq_pkg::OP_SEND, 10'h000, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_SEND, 10'h3FF, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h2AA, 32'h0000_0000, rdarq_pkg::FT_DATA,
                         rdarq_pkg::MIN_FRAME));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h155, 32'hFFFF_FFFF, rdarq_pkg::FT_DATA,
                         MAX_FRAME_LEN));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h3FF, 32'h8000_0000, rdarq_pkg::FT_DATA,
                         11'd2047));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h001, 32'h1234_5678, rdarq_pkg::FT_DATA,
                         11'd4));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h002, 32'h0000_0003, rdarq_pkg::FT_DATA,
                         11'd0));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h003, 32'h0000_0004, 8'd7, 11'd100));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h004, 32'h0000_0005, 8'hFF, MAX_FRAME_LEN));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h005, 32'h0000_0001, rdarq_pkg::FT_ACK,
                         11'd4));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h006, 32'h0000_0001, rdarq_pkg::FT_ACK,
                         rdarq_pkg::MIN_FRAME));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h007, 32'h0000_0040, rdarq_pkg::FT_ACK,
                         rdarq_pkg::MIN_FRAME));
      put_item(make_item(rdarq_pkg::OP_TICK, 10'h000, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_TICK, 10'h000, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 8'hFF, 11'h7FF));
      put_item(make_item(rdarq_pkg::OP_SEND, 10'h0F0, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_TICK, 10'h000, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_TICK, 10'h000, '0, rdarq_pkg::FT_DATA, 11'd0));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h000, 32'h0000_0000, rdarq_pkg::FT_ACK,
                         rdarq_pkg::MIN_FRAME));
      put_item(make_item(rdarq_pkg::OP_FRAME, 10'h000, 32'h0000_0002, rdarq_pkg::FT_ACK,
                         rdarq_pkg::MIN_FRAME));

      // The receiver holds off while a burst of items is offered, so the
      // engine backs up and stalls its request channel.
      stall_reqs++;
      repeat (BURST_ITEMS) put_item(random_item(1'b1));
      settle();

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 2) begin
            src_idle_pct  = 79;
            sink_idle_pct = 15;
         end else if (ph == 4) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         load_config(phase_timeout[ph], phase_period[ph]);
         repeat (PHASE_ITEMS) put_item(random_item(1'b0));
         settle();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
